// ===== rtl/dpss_pkg.sv =====
// ----------------------------------------------------------------------------
// dpss_pkg
// Shared types and defaults for the drum pattern step store.
// ----------------------------------------------------------------------------
package dpss_pkg;

    localparam int PATTERNS_DEF = 64;
    localparam int TRACKS_DEF   = 16;
    localparam int STEPS_DEF    = 32;

    localparam int VEL_W        = 2;
    localparam int SUBSTEPS     = 4;
    localparam int VEL_BYTE_W   = VEL_W * SUBSTEPS;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

endpackage

// ===== rtl/dpss_ram.sv =====
// ----------------------------------------------------------------------------
// dpss_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module dpss_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/drum_pattern_step_store.sv =====
// ----------------------------------------------------------------------------
// drum_pattern_step_store
// Step pattern store: read, write and find-next-active over one row per
// pattern and instrument pair, held in a single RAM.
//
//   channel   valid    ready    payload
//   request   i_valid  o_ready  i_command .. i_set_vel3
//   result    o_valid  i_ready  o_found .. o_vel3
//
// A request reads its row in the accept cycle, then does the search, result
// load and write-back in the lookup state. With the single RAM port, one
// request is in flight at a time.
// After reset a clearing pass zeroes all PATTERNS*TRACKS rows, one a cycle,
// before the first request is taken. A stalled result holds the next request
// in its lookup state until the output register frees up.
// ----------------------------------------------------------------------------
module drum_pattern_step_store #(
    parameter int PATTERNS = dpss_pkg::PATTERNS_DEF,
    parameter int TRACKS   = dpss_pkg::TRACKS_DEF,
    parameter int STEPS    = dpss_pkg::STEPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [5:0] i_pattern,
    input  logic [3:0] i_instrument,
    input  logic [4:0] i_step_index,
    input  logic       i_set_active,
    input  logic       i_set_mute,
    input  logic [1:0] i_set_vel0,
    input  logic [1:0] i_set_vel1,
    input  logic [1:0] i_set_vel2,
    input  logic [1:0] i_set_vel3,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_found,
    output logic [4:0] o_step_out,
    output logic       o_active,
    output logic       o_mute,
    output logic [1:0] o_vel0,
    output logic [1:0] o_vel1,
    output logic [1:0] o_vel2,
    output logic [1:0] o_vel3
);

    import dpss_pkg::*;

    localparam int PAIRS  = PATTERNS * TRACKS;
    localparam int PAT_W  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
    localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int STEP_W = $clog2(STEPS);
    localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int ROW_W  = STEPS * (2 + VEL_BYTE_W);

    t_state r_state, n_state;
    logic [PAIR_W-1:0] r_clr;
    logic [PAIR_W-1:0] r_pair;
    t_cmd r_cmd;
    logic [STEP_W-1:0] r_step;
    logic r_set_active;
    logic r_set_mute;
    logic [VEL_BYTE_W-1:0] r_set_vel;

    logic r_out_valid;
    logic r_found, r_active, r_mute;
    logic [4:0] r_step_out;
    logic [VEL_BYTE_W-1:0] r_vel;

    logic n_found, n_active, n_mute;
    logic [4:0] n_step_out;
    logic [VEL_BYTE_W-1:0] n_vel;

    logic [PAT_W-1:0] pat_tab [64];
    logic [TRK_W-1:0] trk_tab [16];
    logic [STEP_W-1:0] step_tab [32];

    for (genvar g = 0; g < 64; g++) begin : g_pat
        assign pat_tab[g] = PAT_W'(g % PATTERNS);
    end
    for (genvar g = 0; g < 16; g++) begin : g_trk
        assign trk_tab[g] = TRK_W'(g % TRACKS);
    end
    for (genvar g = 0; g < 32; g++) begin : g_step
        assign step_tab[g] = STEP_W'(g % STEPS);
    end

    logic [PAIR_W-1:0] pair_in;
    assign pair_in = PAIR_W'(PAIR_W'(pat_tab[i_pattern]) * PAIR_W'(TRACKS))
                   + PAIR_W'(trk_tab[i_instrument]);

    logic accept, done;
    logic ram_we;
    logic [PAIR_W-1:0] ram_addr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign done    = (r_state == S_LOOK) && (!r_out_valid || i_ready);

    dpss_ram #(
        .WIDTH (ROW_W),
        .DEPTH (PAIRS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    logic [STEPS-1:0] act_word, mute_word, act_hi, act_sel;
    logic [STEP_W-1:0] hit_idx, look_idx;
    logic any_act;
    logic [ROW_W-1:0] n_row;

    assign act_word  = ram_rdata[STEPS-1:0];
    assign mute_word = ram_rdata[2*STEPS-1:STEPS];
    assign act_hi    = act_word & ({STEPS{1'b1}} << r_step);
    assign act_sel   = (|act_hi) ? act_hi : act_word;
    assign any_act   = |act_word;

    always_comb begin
        hit_idx = '0;
        for (int i = STEPS - 1; i >= 0; i--) begin
            if (act_sel[i]) begin
                hit_idx = STEP_W'(i);
            end
        end
    end

    assign look_idx = (r_cmd == CMD_FIND) ? hit_idx : r_step;

    always_comb begin
        n_row = ram_rdata;
        n_row[r_step] = r_set_active;
        n_row[STEPS + r_step] = r_set_mute;
        n_row[2*STEPS + r_step*VEL_BYTE_W +: VEL_BYTE_W] = r_set_vel;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = pair_in;
        ram_wdata = n_row;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_addr = pair_in;
            end
            S_LOOK: begin
                ram_addr = r_pair;
                ram_we   = done && (r_cmd == CMD_WRITE);
            end
            default: begin
                ram_addr = pair_in;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == PAIR_W'(PAIRS - 1)) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_LOOK;
            S_LOOK:  if (done) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_found    = 1'b0;
        n_step_out = '0;
        n_active   = 1'b0;
        n_mute     = 1'b0;
        n_vel      = '0;
        case (r_cmd) inside
            CMD_WRITE: begin
                n_found    = 1'b1;
                n_step_out = 5'(r_step);
                n_active   = r_set_active;
                n_mute     = r_set_mute;
                n_vel      = r_set_vel;
            end
            CMD_READ, CMD_FIND: begin
                if (r_cmd == CMD_READ || any_act) begin
                    n_found    = 1'b1;
                    n_step_out = 5'(look_idx);
                    n_active   = act_word[look_idx];
                    n_mute     = mute_word[look_idx];
                    n_vel      = ram_rdata[2*STEPS + look_idx*VEL_BYTE_W +: VEL_BYTE_W];
                end
            end
            default: begin
                n_found = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd        <= t_cmd'(i_command);
            r_pair       <= pair_in;
            r_step       <= step_tab[i_step_index];
            r_set_active <= i_set_active;
            r_set_mute   <= i_set_mute;
            r_set_vel    <= {i_set_vel3, i_set_vel2, i_set_vel1, i_set_vel0};
        end
        if (done) begin
            r_found    <= n_found;
            r_step_out <= n_step_out;
            r_active   <= n_active;
            r_mute     <= n_mute;
            r_vel      <= n_vel;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_found    = r_found;
    assign o_step_out = r_step_out;
    assign o_active   = r_active;
    assign o_mute     = r_mute;
    assign o_vel0     = r_vel[1:0];
    assign o_vel1     = r_vel[3:2];
    assign o_vel2     = r_vel[5:4];
    assign o_vel3     = r_vel[7:6];

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LOOK) && !o_ready)
        else $error("request accepted without entering lookup");

    a_rise_from_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_LOOK))
        else $error("result appeared without a lookup");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_step_out == 5'd0 && !o_active && !o_mute
            && o_vel0 == 2'd0 && o_vel1 == 2'd0 && o_vel2 == 2'd0 && o_vel3 == 2'd0))
        else $error("failed search result carries data");

    a_write_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || (r_state == S_LOOK && r_cmd == CMD_WRITE)))
        else $error("row write outside clearing or write request");

    a_found_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_cmd == CMD_FIND && any_act) |-> act_word[hit_idx])
        else $error("search hit on an inactive step");

endmodule

// ===== sim/drum_pattern_step_store_tb.sv =====
// ----------------------------------------------------------------------------
// drum_pattern_step_store_tb
// Self-checking bench for the step pattern store. A directed table covers
// empty reads and searches, extreme addresses and field values, unused
// commands, byte-boundary and wrapping searches, and searches that fail
// while mute bits remain set. A long random run follows. It concentrates on
// a few hot pattern/instrument pairs and sometimes wipes one, plants a lone
// active step and sweeps searches across it. Every result is checked against
// a typed table value or a shadow store model. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module drum_pattern_step_store_tb;
    import dpss_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int ROWS         = 1024;
    localparam int CELLS        = 32768;
    localparam bit TYPED        = 1'b1;
    localparam bit PRED         = 1'b0;

    typedef struct packed {
        t_cmd            cmd;
        logic [5:0]      pattern;
        logic [3:0]      instrument;
        logic [4:0]      step;
        logic            set_active;
        logic            set_mute;
        logic [3:0][1:0] set_vel;
    } t_step_req;

    typedef struct packed {
        logic            found;
        logic [4:0]      step_out;
        logic            active;
        logic            mute;
        logic [3:0][1:0] vel;
    } t_step_rsp;

    typedef struct {
        t_step_req req;
        bit        typed;
        t_step_rsp rsp;
    } t_probe_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_command;
    logic [5:0] i_pattern;
    logic [3:0] i_instrument;
    logic [4:0] i_step_index;
    logic       i_set_active;
    logic       i_set_mute;
    logic [1:0] i_set_vel0;
    logic [1:0] i_set_vel1;
    logic [1:0] i_set_vel2;
    logic [1:0] i_set_vel3;
    logic       o_valid;
    logic       i_ready;
    logic       o_found;
    logic [4:0] o_step_out;
    logic       o_active;
    logic       o_mute;
    logic [1:0] o_vel0;
    logic [1:0] o_vel1;
    logic [1:0] o_vel2;
    logic [1:0] o_vel3;

    logic [31:0]     act_rows  [ROWS];
    logic [31:0]     mute_rows [ROWS];
    logic [3:0][1:0] vel_cells [CELLS];

    t_step_rsp  pending_q [$];
    t_probe_row probe_tab [$];
    logic [9:0] hot_pairs [4];
    t_step_rsp  got;
    t_step_rsp  want;

    int mismatches   = 0;
    int results_seen = 0;
    int n_misses     = 0;
    int n_wraps      = 0;
    int cycles       = 0;
    int n_cmd [4]    = '{0, 0, 0, 0};
    bit calm         = 1'b0;

    drum_pattern_step_store dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_pattern    (i_pattern),
        .i_instrument (i_instrument),
        .i_step_index (i_step_index),
        .i_set_active (i_set_active),
        .i_set_mute   (i_set_mute),
        .i_set_vel0   (i_set_vel0),
        .i_set_vel1   (i_set_vel1),
        .i_set_vel2   (i_set_vel2),
        .i_set_vel3   (i_set_vel3),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_step_out   (o_step_out),
        .o_active     (o_active),
        .o_mute       (o_mute),
        .o_vel0       (o_vel0),
        .o_vel1       (o_vel1),
        .o_vel2       (o_vel2),
        .o_vel3       (o_vel3)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_step_req rq(input t_cmd c, input int p, input int i, input int s,
                                     input bit a, input bit m, input logic [7:0] v);
        t_step_req r;
        r.cmd        = c;
        r.pattern    = 6'(p);
        r.instrument = 4'(i);
        r.step       = 5'(s);
        r.set_active = a;
        r.set_mute   = m;
        r.set_vel    = v;
        return r;
    endfunction

    function automatic t_step_rsp rs(input bit f, input int s, input bit a, input bit m,
                                     input logic [7:0] v);
        t_step_rsp r;
        r.found    = f;
        r.step_out = 5'(s);
        r.active   = a;
        r.mute     = m;
        r.vel      = v;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_step_rsp step_view(input logic [9:0] pair, input logic [4:0] s);
        t_step_rsp r;
        r.found    = 1'b1;
        r.step_out = s;
        r.active   = act_rows[pair][s];
        r.mute     = mute_rows[pair][s];
        r.vel      = vel_cells[{pair, s}];
        return r;
    endfunction

    function automatic t_step_rsp apply_step_cmd(input t_step_req q);
        t_step_rsp  r;
        logic [9:0] pair;
        logic [4:0] t;
        bit         hit;
        r    = '0;
        pair = {q.pattern, q.instrument};
        hit  = 1'b0;
        case (q.cmd)
            CMD_READ: r = step_view(pair, q.step);
            CMD_FIND: begin
                for (int k = 0; k < 32; k++) begin
                    t = q.step + 5'(k);
                    if (!hit && act_rows[pair][t]) begin
                        r   = step_view(pair, t);
                        hit = 1'b1;
                    end
                end
            end
            CMD_WRITE: begin
                act_rows[pair][q.step]   = q.set_active;
                mute_rows[pair][q.step]  = q.set_mute;
                vel_cells[{pair, q.step}] = q.set_vel;
                r = step_view(pair, q.step);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_step_req rand_req(input logic [9:0] pair);
        t_step_req r;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.cmd = CMD_WRITE;
        else if (pick < 65)
            r.cmd = CMD_FIND;
        else if (pick < 95)
            r.cmd = CMD_READ;
        else
            r.cmd = CMD_NONE;
        {r.pattern, r.instrument} = pair;
        r.step       = 5'($urandom_range(0, 31));
        r.set_active = ($urandom_range(0, 3) == 0);
        r.set_mute   = 1'($urandom_range(0, 1));
        r.set_vel    = 8'($urandom);
        return r;
    endfunction

    task automatic add_row(input t_step_req q, input bit typed, input t_step_rsp e);
        t_probe_row row;
        row.req   = q;
        row.typed = typed;
        row.rsp   = e;
        probe_tab.push_back(row);
    endtask

    task automatic send_request(input t_step_req q, input int gap, input bit typed,
                                input t_step_rsp typed_rsp);
        t_step_rsp e;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_command    <= q.cmd;
        i_pattern    <= q.pattern;
        i_instrument <= q.instrument;
        i_step_index <= q.step;
        i_set_active <= q.set_active;
        i_set_mute   <= q.set_mute;
        i_set_vel0   <= q.set_vel[0];
        i_set_vel1   <= q.set_vel[1];
        i_set_vel2   <= q.set_vel[2];
        i_set_vel3   <= q.set_vel[3];
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        e = apply_step_cmd(q);
        if (typed)
            e = typed_rsp;
        pending_q.push_back(e);
        n_cmd[q.cmd]++;
        if (q.cmd == CMD_FIND && !e.found)
            n_misses++;
        if (q.cmd == CMD_FIND && e.found && e.step_out < q.step)
            n_wraps++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_found, o_step_out, o_active, o_mute, o_vel3, o_vel2, o_vel1, o_vel0};
            results_seen++;
            if (pending_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: found=%0b step=%0d act=%0b mute=%0b vel=%h",
                             got.found, got.step_out, got.active, got.mute, got.vel);
                mismatches++;
            end else begin
                want = pending_q.pop_front();
                if (got.found !== want.found || got.step_out !== want.step_out ||
                    got.active !== want.active || got.mute !== want.mute ||
                    got.vel !== want.vel) begin
                    if (mismatches < 10)
                        $display(
                            "result %0d mismatch: exp %0b/%0d/%0b/%0b/%h got %0b/%0d/%0b/%0b/%h",
                            results_seen, want.found, want.step_out, want.active,
                            want.mute, want.vel, got.found, got.step_out, got.active,
                            got.mute, got.vel);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, pending_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls
    initial begin
        int stall_left;
        stall_left = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready    <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        t_step_req  q;
        logic [9:0] pair;
        int         sent;
        int         lone;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_command    = CMD_READ;
        i_pattern    = '0;
        i_instrument = '0;
        i_step_index = '0;
        i_set_active = 1'b0;
        i_set_mute   = 1'b0;
        i_set_vel0   = '0;
        i_set_vel1   = '0;
        i_set_vel2   = '0;
        i_set_vel3   = '0;
        for (int n = 0; n < ROWS; n++) begin
            act_rows[n]  = '0;
            mute_rows[n] = '0;
        end
        for (int n = 0; n < CELLS; n++)
            vel_cells[n] = '0;
        for (int n = 0; n < 4; n++)
            hot_pairs[n] = 10'($urandom_range(0, ROWS - 1));

        add_row(rq(CMD_READ,   0,  0,  0, 0, 0, 8'h00), TYPED, rs(1,  0, 0, 0, 8'h00));
        add_row(rq(CMD_READ,  63, 15, 31, 1, 1, 8'hFF), TYPED, rs(1, 31, 0, 0, 8'h00));
        add_row(rq(CMD_FIND,  63, 15, 31, 1, 1, 8'hFF), TYPED, rs(0,  0, 0, 0, 8'h00));
        add_row(rq(CMD_NONE,  63, 15, 31, 1, 1, 8'hFF), TYPED, rs(0,  0, 0, 0, 8'h00));
        add_row(rq(CMD_WRITE, 63, 15, 31, 1, 1, 8'hFF), TYPED, rs(1, 31, 1, 1, 8'hFF));
        add_row(rq(CMD_WRITE, 63, 15,  0, 0, 0, 8'h00), TYPED, rs(1,  0, 0, 0, 8'h00));
        add_row(rq(CMD_FIND,  63, 15,  0, 0, 0, 8'h00), PRED, '0);
        add_row(rq(CMD_FIND,  63, 15, 31, 0, 0, 8'h00), PRED, '0);
        add_row(rq(CMD_NONE,  63, 15, 31, 0, 0, 8'h00), TYPED, rs(0,  0, 0, 0, 8'h00));
        add_row(rq(CMD_READ,  63, 15, 31, 0, 0, 8'h00), PRED, '0);
        add_row(rq(CMD_WRITE,  0,  0,  7, 1, 0, 8'b00_11_10_01),
                TYPED, rs(1, 7, 1, 0, 8'b00_11_10_01));
        add_row(rq(CMD_WRITE,  0,  0,  8, 1, 1, 8'b11_00_01_10),
                TYPED, rs(1, 8, 1, 1, 8'b11_00_01_10));
        add_row(rq(CMD_FIND,   0,  0,  8, 0, 0, 8'h00), PRED, '0);
        add_row(rq(CMD_FIND,   0,  0,  9, 0, 0, 8'h00), PRED, '0);
        add_row(rq(CMD_FIND,   0,  0,  0, 0, 0, 8'h00), PRED, '0);
        add_row(rq(CMD_WRITE,  0,  0, 31, 1, 1, 8'hC0), TYPED, rs(1, 31, 1, 1, 8'hC0));
        add_row(rq(CMD_FIND,   0,  0,  9, 0, 0, 8'h00), PRED, '0);
        add_row(rq(CMD_WRITE,  0,  0,  7, 0, 1, 8'hFF), TYPED, rs(1,  7, 0, 1, 8'hFF));
        add_row(rq(CMD_FIND,   0,  0,  0, 0, 0, 8'h00), PRED, '0);
        add_row(rq(CMD_WRITE,  0,  0,  8, 0, 1, 8'h00), TYPED, rs(1,  8, 0, 1, 8'h00));
        add_row(rq(CMD_WRITE,  0,  0, 31, 0, 0, 8'h55), TYPED, rs(1, 31, 0, 0, 8'h55));
        add_row(rq(CMD_FIND,   0,  0,  5, 1, 1, 8'hFF), TYPED, rs(0,  0, 0, 0, 8'h00));
        add_row(rq(CMD_WRITE,  1,  0, 15, 1, 0, 8'hAA), TYPED, rs(1, 15, 1, 0, 8'hAA));
        add_row(rq(CMD_FIND,   0,  0, 15, 0, 0, 8'h00), TYPED, rs(0,  0, 0, 0, 8'h00));
        add_row(rq(CMD_READ,   0,  0,  7, 0, 0, 8'h00), PRED, '0);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_tab[n])
            send_request(probe_tab[n].req, pick_gap(), probe_tab[n].typed, probe_tab[n].rsp);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 250 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 41)
                wait_drained();
            if ($urandom_range(0, 99) < 3) begin
                // wipe a hot pair, plant one active step, sweep searches over it
                pair = hot_pairs[$urandom_range(0, 3)];
                for (int s = 0; s < 32; s++) begin
                    q            = rand_req(pair);
                    q.cmd        = CMD_WRITE;
                    q.step       = 5'(s);
                    q.set_active = 1'b0;
                    send_request(q, pick_gap(), PRED, '0);
                end
                q     = rand_req(pair);
                q.cmd = CMD_FIND;
                send_request(q, pick_gap(), PRED, '0);
                lone         = $urandom_range(0, 31);
                q            = rand_req(pair);
                q.cmd        = CMD_WRITE;
                q.step       = 5'(lone);
                q.set_active = 1'b1;
                send_request(q, pick_gap(), PRED, '0);
                repeat (6) begin
                    q     = rand_req(pair);
                    q.cmd = CMD_FIND;
                    send_request(q, pick_gap(), PRED, '0);
                end
                sent += 40;
            end else begin
                if ($urandom_range(0, 99) < 80)
                    pair = hot_pairs[$urandom_range(0, 3)];
                else
                    pair = 10'($urandom_range(0, ROWS - 1));
                send_request(rand_req(pair), pick_gap(), PRED, '0);
                sent++;
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("requests: %0d read, %0d find, %0d write, %0d unused; %0d results checked",
                 n_cmd[CMD_READ], n_cmd[CMD_FIND], n_cmd[CMD_WRITE], n_cmd[CMD_NONE],
                 results_seen);
        $display("searches: %0d came up empty, %0d wrapped past the last step; %0d mismatches",
                 n_misses, n_wraps, mismatches);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
